// ===== sv/tslg_pkg.sv =====
// ----------------------------------------------------------------------------
// tslg_pkg
// Shared constants, types and helper functions of the tremolo gain unit.
// ----------------------------------------------------------------------------
package tslg_pkg;

	// table and sample geometry
	localparam int TABLE_BITS   = 14;
	localparam int SAMPLE_WIDTH = 16;
	localparam int FRAC_BITS    = 18;
	localparam int PHASE_W      = TABLE_BITS + FRAC_BITS;
	localparam int QUARTER      = 1 << (TABLE_BITS - 2);
	localparam int ROM_DEPTH    = QUARTER + 1;
	localparam int ROM_AW       = TABLE_BITS - 1;
	localparam int SINE_W       = 15;
	localparam int SINE_MAX     = (1 << SINE_W) - 1;

	// configuration
	localparam int STEP_W     = 24;
	localparam int DEPTH_W    = 16;
	localparam int FULL_DEPTH = 32768;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_DEPTH      = 2'd1,
		CFG_STEREO     = 2'd2
	} cfg_reg_t;

	// sine series arithmetic, Q30
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam int THETA_W     = 31;
	localparam int T2_W        = 32;
	localparam int N_W         = 33;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 34;
	localparam int Q0_W        = N_W + RECIP_W - RECIP_SHIFT;
	localparam int SUM_W       = 33;
	localparam int DIV_W       = 8;
	localparam int K_W         = 3;
	localparam int TERMS       = 6;

	// gain datapath
	localparam int G_W    = 32;
	localparam int SD_W   = SINE_W + 1 + DEPTH_W + 1;
	localparam int PROD_W = SAMPLE_WIDTH + G_W;

	typedef enum logic [2:0] {
		FS_THETA,
		FS_T2,
		FS_MUL,
		FS_RECIP,
		FS_FIX,
		FS_WRITE,
		FS_DONE
	} fill_state_t;

	typedef struct packed {
		logic              we;
		logic [ROM_AW-1:0] addr;
		logic [SINE_W-1:0] data;
	} rom_wr_t;

	typedef struct packed {
		logic [ROM_AW-1:0] addr;
		logic              neg;
	} sine_look_t;

	// divisor (2k)(2k+1) of series term k
	function automatic logic [DIV_W-1:0] series_div(input logic [K_W-1:0] k);
		logic [DIV_W-1:0] d;
		case (k)
			3'd1:    d = 8'd6;
			3'd2:    d = 8'd20;
			3'd3:    d = 8'd42;
			3'd4:    d = 8'd72;
			3'd5:    d = 8'd110;
			3'd6:    d = 8'd156;
			default: d = 8'd6;
		endcase
		return d;
	endfunction

	// floor(2^34 / divisor); quotient comes out low by at most one
	function automatic logic [RECIP_W-1:0] series_recip(input logic [K_W-1:0] k);
		logic [RECIP_W-1:0] m;
		case (k)
			3'd1:    m = 32'd2863311530;
			3'd2:    m = 32'd858993459;
			3'd3:    m = 32'd409044504;
			3'd4:    m = 32'd238609294;
			3'd5:    m = 32'd156180628;
			3'd6:    m = 32'd110127366;
			default: m = 32'd2863311530;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/tslg_ram.sv =====
// ----------------------------------------------------------------------------
// tslg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tslg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/tslg_sine_fill.sv =====
// ----------------------------------------------------------------------------
// tslg_sine_fill
// Builds the quarter-wave sine table after reset, one entry per pass of a
// Taylor series sequencer with its own multiplier for each step.
// ----------------------------------------------------------------------------
module tslg_sine_fill import tslg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	output rom_wr_t wr,
	output logic    done
);

	fill_state_t state_q, state_d;

	logic [ROM_AW-1:0]         x_q;
	logic [K_W-1:0]            k_q;
	logic [THETA_W-1:0]        theta_q;
	logic [T2_W-1:0]           t2_q;
	logic [THETA_W-1:0]        term_q;
	logic [N_W-1:0]            n_q;
	logic [Q0_W-1:0]           q0_q;
	logic signed [SUM_W-1:0]   sum_q;

	logic [ROM_AW+THETA_W-1:0] theta_full;
	logic [2*THETA_W-1:0]      sq_full;
	logic [THETA_W+T2_W-1:0]   tp_full;
	logic [N_W+RECIP_W-1:0]    rp_full;
	logic [N_W-1:0]            qd;
	logic [N_W-1:0]            rem;
	logic [DIV_W-1:0]          div_k;
	logic [THETA_W-1:0]        term_next;
	logic [SUM_W-2:0]          sum_pos;
	logic [SUM_W-1+SINE_W-1:0] qv_full;
	logic [SUM_W-1+SINE_W-31:0] qv;
	logic [SINE_W-1:0]         qv_sat;

	// theta = x * pi/2 / QUARTER in Q30
	assign theta_full = (ROM_AW+THETA_W)'(x_q) * (ROM_AW+THETA_W)'(HALF_PI_Q30);
	assign sq_full    = (2*THETA_W)'(theta_q) * (2*THETA_W)'(theta_q);
	assign tp_full    = (THETA_W+T2_W)'(term_q) * (THETA_W+T2_W)'(t2_q);
	assign rp_full    = (N_W+RECIP_W)'(n_q) * (N_W+RECIP_W)'(series_recip(k_q));

	// reciprocal quotient fix-up
	assign div_k     = series_div(k_q);
	assign qd        = N_W'(q0_q) * N_W'(div_k);
	assign rem       = n_q - qd;
	assign term_next = (rem >= N_W'(div_k)) ? THETA_W'(q0_q) + 1'b1 : THETA_W'(q0_q);

	// scale to Q15 with rounding, clamp to the positive range
	assign sum_pos = sum_q[SUM_W-1] ? '0 : sum_q[SUM_W-2:0];
	assign qv_full = (SUM_W-1+SINE_W)'(sum_pos) * (SUM_W-1+SINE_W)'(SINE_MAX)
		+ (SUM_W-1+SINE_W)'(64'd1 << 29);
	assign qv      = qv_full[SUM_W-1+SINE_W-1:30];
	assign qv_sat  = (qv > (SUM_W-1+SINE_W-30)'(SINE_MAX)) ? SINE_W'(SINE_MAX)
		: qv[SINE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_THETA;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		wr.we   = 1'b0;
		wr.addr = x_q;
		wr.data = qv_sat;
		case (state_q)
			FS_THETA: state_d = FS_T2;
			FS_T2:    state_d = FS_MUL;
			FS_MUL:   state_d = FS_RECIP;
			FS_RECIP: state_d = FS_FIX;
			FS_FIX: begin
				state_d = (k_q == K_W'(TERMS)) ? FS_WRITE : FS_MUL;
			end
			FS_WRITE: begin
				wr.we   = 1'b1;
				state_d = (x_q == ROM_AW'(QUARTER)) ? FS_DONE : FS_THETA;
			end
			FS_DONE:  state_d = FS_DONE;
			default:  state_d = FS_THETA;
		endcase
	end

	assign done = (state_q == FS_DONE);

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			k_q <= K_W'(1);
		end else begin
			if (state_q == FS_T2) begin
				k_q <= K_W'(1);
			end else if (state_q == FS_FIX) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == FS_WRITE && x_q != ROM_AW'(QUARTER)) begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// series datapath
	always_ff @(posedge clk) begin
		case (state_q)
			FS_THETA: theta_q <= theta_full[TABLE_BITS-2 +: THETA_W];
			FS_T2: begin
				t2_q   <= sq_full[30 +: T2_W];
				term_q <= theta_q;
				sum_q  <= SUM_W'(signed'({2'b00, theta_q}));
			end
			FS_MUL:   n_q  <= tp_full[30 +: N_W];
			FS_RECIP: q0_q <= rp_full[RECIP_SHIFT +: Q0_W];
			FS_FIX: begin
				term_q <= term_next;
				if (k_q[0]) begin
					sum_q <= sum_q - SUM_W'(signed'({2'b00, term_next}));
				end else begin
					sum_q <= sum_q + SUM_W'(signed'({2'b00, term_next}));
				end
			end
			default: ;
		endcase
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FS_DONE |=> state_q == FS_DONE)
		else $error("fill sequencer left done");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FS_FIX |-> (k_q >= K_W'(1) && k_q <= K_W'(TERMS)))
		else $error("series term index out of range");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> x_q <= ROM_AW'(QUARTER))
		else $error("fill write beyond quarter table");

endmodule

// ===== sv/tslg_phase_gen.sv =====
// ----------------------------------------------------------------------------
// tslg_phase_gen
// Phase accumulator and channel flag; maps phase to a quarter-table lookup.
// ----------------------------------------------------------------------------
module tslg_phase_gen import tslg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [STEP_W-1:0] phase_step,
	input  logic              stereo,
	output sine_look_t        look
);

	logic [PHASE_W-1:0]    acc_q;
	logic                  flag_q;
	logic                  flag_next;
	logic [TABLE_BITS-1:0] idx;
	logic [1:0]            quad;
	logic [ROM_AW-2:0]     r;

	assign idx  = acc_q[PHASE_W-1 -: TABLE_BITS];
	assign quad = idx[TABLE_BITS-1 -: 2];
	assign r    = idx[TABLE_BITS-3:0];

	// odd quadrants run the table backward, upper half is negated
	assign look.addr = quad[0] ? (ROM_AW'(QUARTER) - ROM_AW'(r)) : ROM_AW'(r);
	assign look.neg  = quad[1];

	assign flag_next = stereo ? ~flag_q : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			flag_q <= 1'b0;
		end else if (step_en) begin
			flag_q <= flag_next;
			if (!flag_next) begin
				acc_q <= acc_q + PHASE_W'(phase_step);
			end
		end
	end

endmodule

// ===== sv/tremolo_sine_lfo_gain_unit.sv =====
// Path: an accepted sample beat is registered at s1, at s2 and then at the output.
// Throughput: one beat per cycle; a stalled output stalls the whole pipeline.
// Reset: phase, channel flag and config return to defaults, then the quarter-wave
//   sine memory is built by a series sequencer, one entry per pass, 4097 entries,
//   with in_ready low. Config writes are taken at any time.
// ----------------------------------------------------------------------------
// tremolo_sine_lfo_gain_unit
// Sine LFO tremolo: each sample is scaled by (1 + sin(phase) * depth) / 2.
// ----------------------------------------------------------------------------
module tremolo_sine_lfo_gain_unit import tslg_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	// sample input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	// sample output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

	// config registers
	logic [STEP_W-1:0]  phase_step_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               stereo_q;

	// fill sequencer and lookup
	rom_wr_t    fill_wr;
	logic       fill_done;
	sine_look_t look;
	logic [SINE_W-1:0] rom_rdata;

	// pipeline control
	logic adv;
	logic in_beat;
	logic valid_s1, valid_s2, out_valid_q;

	// pipeline payload
	logic                           neg_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1, sample_s2;
	logic signed [G_W-1:0]          sd_s2;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	logic signed [SINE_W:0]  sine_val;
	logic [DEPTH_W-1:0]      depth_sat;
	logic signed [SD_W-1:0]  sd_full;
	logic signed [G_W-1:0]   gain;
	logic signed [PROD_W-1:0] prod;

	// ------------------------------------------------------------------
	// Config port, always ready; unknown indexes fall through
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= STEP_W'(447392);
			depth_q      <= DEPTH_W'(16384);
			stereo_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PHASE_STEP: phase_step_q <= cfg_data[STEP_W-1:0];
				CFG_DEPTH:      depth_q      <= cfg_data[DEPTH_W-1:0];
				CFG_STEREO:     stereo_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sine memory: quarter wave, written by the fill sequencer, then read
	// once per accepted beat
	// ------------------------------------------------------------------
	tslg_sine_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fill_wr),
		.done   (fill_done)
	);

	tslg_ram #(
		.WIDTH (SINE_W),
		.DEPTH (ROM_DEPTH)
	) u_sine_ram (
		.clk   (clk),
		.we    (fill_wr.we),
		.waddr (fill_wr.addr),
		.wdata (fill_wr.data),
		.re    (in_beat),
		.raddr (look.addr),
		.rdata (rom_rdata)
	);

	// ------------------------------------------------------------------
	// Phase: lookup uses the phase before this beat's advance
	// ------------------------------------------------------------------
	tslg_phase_gen u_phase (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (in_beat),
		.phase_step (phase_step_q),
		.stereo     (stereo_q),
		.look       (look)
	);

	// ------------------------------------------------------------------
	// Pipeline: s1 memory read, s2 sine*depth, output sample*gain.
	// One advance enable for all stages; memory read data holds while
	// stalled since no new read is issued.
	// ------------------------------------------------------------------
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && fill_done;
	assign in_beat  = in_valid && in_ready;

	assign sine_val  = neg_s1 ? -$signed({1'b0, rom_rdata}) : $signed({1'b0, rom_rdata});
	assign depth_sat = (depth_q > DEPTH_W'(FULL_DEPTH)) ? DEPTH_W'(FULL_DEPTH) : depth_q;
	assign sd_full   = SD_W'(sine_val) * $signed({1'b0, depth_sat});

	// gain = 1 + sin*depth in Q30; the extra bit of shift does the halving
	assign gain = sd_s2 + G_W'(64'd1 << 30);
	assign prod = PROD_W'(sample_s2) * PROD_W'(gain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_beat;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			neg_s1    <= look.neg;
			sample_s1 <= sample_in;
		end
		if (adv && valid_s1) begin
			sd_s2     <= G_W'(sd_full);
			sample_s2 <= sample_s1;
		end
		if (adv && valid_s2) begin
			sample_out_q <= prod[G_W-1 +: SAMPLE_WIDTH];
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_no_write_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |-> !fill_wr.we)
		else $error("sine memory written after fill");

	a_fill_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(fill_done))
		else $error("fill done dropped");

	a_beat_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> valid_s1)
		else $error("accepted beat lost before first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv) |=> (valid_s2 && $stable(sd_s2)))
		else $error("second stage changed under stall");

endmodule

// ===== tb/tremolo_sine_lfo_gain_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tremolo_sine_lfo_gain_unit_tb
// Self-checking bench for the sine LFO tremolo. Every accepted sample beat is
// run through an in-bench gain predictor (own sine table, phase accumulator
// and channel flag) and each output beat is compared in order. A short table
// of directed beats comes first, then randomized register settings with
// randomized samples, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tremolo_sine_lfo_gain_unit_tb;
	import tslg_pkg::*;

	// index that maps to no register, must be ignored by the block
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int TIMEOUT_NS   = 3_000_000; // watchdog limit, spans the sine fill pass and the run
	localparam int MAX_IDLE     = 12;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_BEATS  = 200;
	localparam int TABLE_SIZE   = 1 << TABLE_BITS;
	localparam int DRAIN_CYCLES = 6;     // pipeline is three stages deep

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	// one row of the directed part: either a register write or a sample beat
	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		sample_t               smp;
		bit                    typed;  // result written into the row by hand
		sample_t               want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	sample_t               sample_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	sample_t               sample_out;

	// predictor state: register shadows plus LFO phase and channel flag
	sample_t               sine_lut [TABLE_SIZE];
	logic [STEP_W-1:0]     step_q   = 24'd447392;
	logic [DEPTH_W-1:0]    depth_q  = 16'd16384;
	logic                  stereo_q = 1'b0;
	logic [PHASE_W-1:0]    lfo_phase = '0;
	logic                  chan_odd  = 1'b0;

	sample_t               expected_samples [$];
	stim_row_t             directed_rows [$];

	// idle control, flipped per phase so some stretches run back to back
	bit                    tx_idle_on = 1'b1;
	bit                    rx_idle_on = 1'b1;
	int                    rx_stall   = 0;
	sample_t               rx_want;

	int                    n_errors  = 0;
	int                    n_items   = 0;
	int                    n_stereo  = 0;
	int                    n_results = 0;
	int                    n_cfg     = 0;

	tremolo_sine_lfo_gain_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// First quadrant of the sine, Q15. Taylor series in Q30 with every
	// intermediate truncated the same way the hardware sequencer does it.
	function automatic longint quarter_wave(input int x);
		longint theta, t2, term, acc, q;
		int     k;
		theta = (longint'(x) * 64'sd1686629713) >>> (TABLE_BITS - 2);
		t2    = (theta * theta) >>> 30;
		term  = theta;
		acc   = theta;
		for (k = 1; k <= TERMS; k++) begin
			term = ((term * t2) >>> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2)
				acc -= term;
			else
				acc += term;
		end
		if (acc < 0)
			acc = 0;
		q = (acc * SINE_MAX + (longint'(1) <<< 29)) >>> 30;
		if (q > SINE_MAX)
			q = SINE_MAX;
		return q;
	endfunction

	// Gain for the current phase, then step the channel flag and the phase.
	// Depth saturates at full scale; the >>> 31 floors and also halves.
	function automatic sample_t gain_predict(input sample_t s);
		longint d, g, prod;
		d    = (depth_q > FULL_DEPTH) ? FULL_DEPTH : depth_q;
		g    = (longint'(1) <<< 30) + longint'(sine_lut[lfo_phase[PHASE_W-1:FRAC_BITS]]) * d;
		prod = (longint'(s) * g) >>> 31;
		if (stereo_q)
			chan_odd = ~chan_odd;
		else
			chan_odd = 1'b0;
		if (!chan_odd)
			lfo_phase = lfo_phase + step_q;
		return prod[SAMPLE_WIDTH-1:0];
	endfunction

	function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r        = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_sample_row(input sample_t s, input bit typed, input sample_t want);
		stim_row_t r;
		r       = '{default: '0};
		r.smp   = s;
		r.typed = typed;
		r.want  = want;
		directed_rows.push_back(r);
	endfunction

	// Register write; only called with the pipeline empty.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PHASE_STEP: step_q   = data[STEP_W-1:0];
			CFG_DEPTH:      depth_q  = data[DEPTH_W-1:0];
			CFG_STEREO:     stereo_q = data[0];
			default:        ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	// Sample beat with a lead-in gap, random while tx idling is on. Valid is left
	// high after the beat so a zero gap on the next call keeps the stream back to back.
	task automatic send_sample(input sample_t s, input bit typed, input sample_t want);
		int      gap;
		sample_t guess;
		gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		guess = gain_predict(s);
		expected_samples.push_back(typed ? want : guess);
		n_items++;
		if (stereo_q)
			n_stereo++;
	endtask

	// Hold the sender off until every predicted beat has come out.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	// Output side: check each beat against the oldest prediction, then
	// drop ready for a random number of cycles before the next beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$error("sample_out: beat with nothing expected, actual %0d", sample_out);
					n_errors++;
				end else begin
					rx_want = expected_samples.pop_front();
					if (sample_out !== rx_want) begin
						$error("sample_out: expected %0d, actual %0d", rx_want, sample_out);
						n_errors++;
					end
				end
				n_results++;
				rx_stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
				out_ready <= (rx_stall == 0);
			end else if (!out_ready) begin
				if (rx_stall <= 1)
					out_ready <= 1'b1;
				else
					rx_stall--;
			end
		end
	end

	initial begin
		int                    i, ph, n, quad, r, dval;
		longint                v;
		logic [CFG_DATA_W-1:0] cdata;
		sample_t               smp;

		// full-cycle table from quarter-wave symmetry
		for (i = 0; i < TABLE_SIZE; i++) begin
			quad = i >> (TABLE_BITS - 2);
			r    = i & (QUARTER - 1);
			v    = (quad & 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
			if (quad & 2)
				v = -v;
			sine_lut[i] = v[SAMPLE_WIDTH-1:0];
		end

		// Directed part. Right after reset the phase is zero and the sine is
		// zero, so the gain is exactly one half; with depth zero it stays there.
		add_sample_row(32767, 1, 16383);
		add_sample_row(-32768, 0, 0);
		add_sample_row(0, 1, 0);
		add_sample_row(-1, 0, 0);
		add_cfg_row(CFG_DEPTH, 24'd0);
		add_sample_row(32767, 1, 16383);
		add_sample_row(-32768, 1, -16384);
		add_sample_row(-1, 1, -1);
		add_sample_row(1, 1, 0);
		// full depth with a frozen phase
		add_cfg_row(CFG_DEPTH, CFG_DATA_W'(FULL_DEPTH));
		add_cfg_row(CFG_PHASE_STEP, 24'd0);
		add_sample_row(32767, 0, 0);
		add_sample_row(-32768, 0, 0);
		add_sample_row(21845, 0, 0);
		// depth beyond full scale saturates; phase step at its largest value
		add_cfg_row(CFG_DEPTH, 24'hFFFFFF);
		add_cfg_row(CFG_PHASE_STEP, 24'hFFFFFF);
		add_sample_row(32767, 0, 0);
		add_sample_row(-32768, 0, 0);
		add_sample_row(-12345, 0, 0);
		// stereo pairs, odd count so the flag is left on the second channel
		add_cfg_row(CFG_STEREO, 24'd1);
		add_sample_row(32767, 0, 0);
		add_sample_row(-32768, 0, 0);
		add_sample_row(4660, 0, 0);
		add_sample_row(-4660, 0, 0);
		add_sample_row(1, 0, 0);
		// back to mono with the flag set: flag clears, phase steps every beat
		add_cfg_row(CFG_STEREO, 24'd0);
		add_sample_row(32767, 0, 0);
		add_sample_row(-32768, 0, 0);
		// write to an unmapped index, nothing may change
		add_cfg_row(CFG_UNUSED, 24'hFFFFFF);
		add_sample_row(100, 0, 0);
		add_sample_row(-100, 0, 0);

		// single reset at the start; the sine fill pass follows with in_ready low
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_cfg) begin
				wait_drain();
				write_reg(directed_rows[k].idx, directed_rows[k].data);
			end else begin
				send_sample(directed_rows[k].smp, directed_rows[k].typed, directed_rows[k].want);
			end
		end

		// Random part: each phase drains, picks new settings, then streams.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drain();
			tx_idle_on = (ph % 3) != 1;
			rx_idle_on = (ph % 4) != 2;

			case ($urandom_range(0, 4))
				0:       cdata = '0;
				1:       cdata = '1;
				2:       cdata = CFG_DATA_W'($urandom_range(0, 1 << 20));
				default: cdata = CFG_DATA_W'($urandom);
			endcase
			write_reg(CFG_PHASE_STEP, cdata);

			case ($urandom_range(0, 4))
				0:       dval = 0;
				1:       dval = FULL_DEPTH;
				2:       dval = $urandom_range(FULL_DEPTH + 1, 65535);
				default: dval = $urandom_range(0, FULL_DEPTH);
			endcase
			// upper data bits are don't-care for the 16-bit register
			cdata = CFG_DATA_W'($urandom & 32'hFF0000) | CFG_DATA_W'(dval);
			write_reg(CFG_DEPTH, cdata);

			cdata = CFG_DATA_W'($urandom & 32'hFFFFFE) | CFG_DATA_W'($urandom_range(0, 1));
			write_reg(CFG_STEREO, cdata);

			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

			n = PHASE_BEATS + $urandom_range(0, 25);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(0, 7))
					0:       smp = 16'sh7FFF;
					1:       smp = 16'sh8000;
					2:       smp = SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
					default: smp = SAMPLE_WIDTH'($urandom);
				endcase
				send_sample(smp, 0, 0);
			end
		end

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d sample beats (%0d in stereo mode), %0d register writes, %0d random phases",
			n_items, n_stereo, n_cfg, RAND_PHASES);
		$display("Checked %0d output beats, %0d mismatches", n_results, n_errors);
		if (n_errors == 0 && expected_samples.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$error("timeout with %0d beats still expected", expected_samples.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/tslg_pkg.sv
sv/tslg_ram.sv
sv/tslg_sine_fill.sv
sv/tslg_phase_gen.sv
sv/tremolo_sine_lfo_gain_unit.sv
tb/tremolo_sine_lfo_gain_unit_tb.sv
